/* rtl/core/rlf_pkg.sv */
// ----------------------------------------------------------------------------
// rlf_pkg
// Shared types and constants of the response line framer.
// ----------------------------------------------------------------------------
package rlf_pkg;

    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_PROMPT = 8'h3E;
    localparam logic [7:0] CH_NUL    = 8'h00;

    localparam logic [7:0] MIN_CHUNK = 8'd20;
    localparam logic [7:0] MAX_CHUNK = 8'd244;

    localparam int unsigned SLOTS = 3;

    typedef enum logic [0:0] {
        CFG_LINK_UP       = 1'b0,
        CFG_CHUNK_PAYLOAD = 1'b1
    } cfg_index_t;

    typedef enum logic [0:0] {
        OP_TEXT = 1'b0,
        OP_END  = 1'b1
    } op_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       chunk_end;
        logic       response_end;
    } result_t;

    typedef struct packed {
        logic [1:0]          count;
        result_t [SLOTS-1:0] slot;
    } burst_t;

    function automatic logic [7:0] clamp_chunk(input logic [7:0] size);
        logic [7:0] c;
        c = size;
        if (c < MIN_CHUNK)
        begin
            c = MIN_CHUNK;
        end
        if (c > MAX_CHUNK)
        begin
            c = MAX_CHUNK;
        end
        return c;
    endfunction

endpackage

/* rtl/core/rlf_framer.sv */
// ----------------------------------------------------------------------------
// rlf_framer
// Turns one accepted input beat into a burst of up to three framed bytes and
// tracks the chunk fill count and the pending CR-LF state.
// ----------------------------------------------------------------------------
module rlf_framer
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            accept,
    input  logic            operation,
    input  logic [7:0]      text_char,
    input  logic            add_line_feed,
    input  logic            link_up,
    input  logic [7:0]      chunk_payload,
    output rlf_pkg::burst_t burst
);
    import rlf_pkg::*;

    logic [7:0] fill_count_reg;
    logic [7:0] fill_count_next;
    logic       skip_next_lf_reg;
    logic       skip_next_lf_next;

    always_comb
    begin
        logic [7:0]       cap;
        logic [7:0]       fill;
        logic [1:0]       n;
        logic [SLOTS-1:0][7:0] bytes;
        logic [SLOTS-1:0] prompt;

        cap               = clamp_chunk(chunk_payload);
        n                 = 2'd0;
        bytes             = '0;
        prompt            = '0;
        skip_next_lf_next = skip_next_lf_reg;
        burst             = '0;

        if (!link_up)
        begin
            skip_next_lf_next = 1'b0;
        end
        else if (operation == OP_END)
        begin
            bytes[0]          = CH_CR;
            skip_next_lf_next = 1'b0;
            if (add_line_feed)
            begin
                bytes[1]  = CH_LF;
                bytes[2]  = CH_PROMPT;
                prompt[2] = 1'b1;
                n         = 2'd3;
            end
            else
            begin
                bytes[1]  = CH_PROMPT;
                prompt[1] = 1'b1;
                n         = 2'd2;
            end
        end
        else if (text_char == CH_LF && skip_next_lf_reg)
        begin
            skip_next_lf_next = 1'b0;
        end
        else if (text_char == CH_CR || text_char == CH_LF)
        begin
            bytes[0]          = CH_CR;
            bytes[1]          = CH_LF;
            n                 = add_line_feed ? 2'd2 : 2'd1;
            skip_next_lf_next = (text_char == CH_CR);
        end
        else if (text_char == CH_NUL)
        begin
            skip_next_lf_next = 1'b0;
        end
        else
        begin
            bytes[0]          = text_char;
            n                 = 2'd1;
            skip_next_lf_next = 1'b0;
        end

        fill = fill_count_reg;
        for (int i = 0; i < SLOTS; i++)
        begin
            burst.slot[i].out_byte     = bytes[i];
            burst.slot[i].response_end = prompt[i];
            if (2'(i) < n)
            begin
                fill = fill + 8'd1;
                if (prompt[i] || fill >= cap)
                begin
                    burst.slot[i].chunk_end = 1'b1;
                    fill = 8'd0;
                end
            end
        end
        burst.count = n;

        if (!link_up || operation == OP_END)
        begin
            fill_count_next = 8'd0;
        end
        else
        begin
            fill_count_next = fill;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_count_reg   <= 8'd0;
            skip_next_lf_reg <= 1'b0;
        end
        else if (accept)
        begin
            fill_count_reg   <= fill_count_next;
            skip_next_lf_reg <= skip_next_lf_next;
        end
    end

endmodule

/* rtl/core/rlf_burst_buffer.sv */
// ----------------------------------------------------------------------------
// rlf_burst_buffer
// Holds one burst of framed bytes and hands it out a beat at a time; a new
// burst loads in the cycle the last byte of the previous one is taken.
// ----------------------------------------------------------------------------
module rlf_burst_buffer
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            load,
    input  rlf_pkg::burst_t burst,
    output logic            load_ready,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [7:0]      m_tdata,   // [7:0] out_byte
    output logic [1:0]      m_tuser,   // [0] chunk_end, [1] response_end
    output logic            m_tlast    // run_last
);
    import rlf_pkg::*;

    logic [1:0]                count_reg;
    logic [1:0]                count_next;
    result_t [SLOTS-1:0]       slot_reg;
    result_t [SLOTS-1:0]       slot_next;
    logic                      pop;

    assign m_tvalid   = (count_reg != 2'd0);
    assign m_tlast    = (count_reg == 2'd1);
    assign m_tdata    = slot_reg[0].out_byte;
    assign m_tuser    = {slot_reg[0].response_end, slot_reg[0].chunk_end};
    assign pop        = m_tvalid && m_tready;
    assign load_ready = !m_tvalid || (pop && m_tlast);

    always_comb
    begin
        count_next = count_reg;
        slot_next  = slot_reg;
        if (pop)
        begin
            count_next = count_reg - 2'd1;
            for (int i = 0; i < SLOTS - 1; i++)
            begin
                slot_next[i] = slot_reg[i + 1];
            end
        end
        if (load)
        begin
            count_next = burst.count;
            slot_next  = burst.slot;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
    end

endmodule

/* rtl/core/response_line_framer_unit.sv */
// ----------------------------------------------------------------------------
// response_line_framer_unit
// Frames response text into bytes for a notification link.
//
// Input stream: one beat per character or end-of-response marker; s_tuser
// carries the operation, s_tdata the character and the line feed flag.
// Output stream: one beat per framed byte; m_tuser flags chunk and response
// ends, m_tlast marks the last byte caused by an input beat.
// Configuration: cfg_we writes cfg_wdata to register cfg_index
// (0 link_up, 1 chunk_payload) at the clock edge; write only while idle.
// First output byte: in the cycle after its input beat is accepted.
// Throughput: the output stage emits one byte per cycle while m_tready is
// high. An ordinary character yields one byte, a line end one or two and
// an end of response two or three; a new beat is taken as the last byte
// of the previous burst is taken, or whenever no byte is held.
// Stall: the held burst waits for m_tready; s_tready drops until its last
// byte is taken, and a new beat loads in that same cycle.
// Reset: link down, chunk size 20, fill count and CR state cleared, output
// empty.
// ----------------------------------------------------------------------------
module response_line_framer_unit
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [15:0] s_tdata,  // [7:0] text_char, [8] add_line_feed, zero fill
    input  logic       s_tuser,   // [0] operation
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic [1:0] m_tuser,   // [0] chunk_end, [1] response_end
    output logic       m_tlast,   // run_last
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [7:0] cfg_wdata
);
    import rlf_pkg::*;

    logic       link_up_reg;
    logic [7:0] chunk_payload_reg;
    logic       accept;
    burst_t     burst;

    assign accept = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_up_reg       <= 1'b0;
            chunk_payload_reg <= 8'd20;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_LINK_UP:       link_up_reg       <= cfg_wdata[0];
                CFG_CHUNK_PAYLOAD: chunk_payload_reg <= cfg_wdata;
                default:           link_up_reg       <= link_up_reg;
            endcase
        end
    end

    rlf_framer u_framer
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .operation     (s_tuser),
        .text_char     (s_tdata[7:0]),
        .add_line_feed (s_tdata[8]),
        .link_up       (link_up_reg),
        .chunk_payload (chunk_payload_reg),
        .burst         (burst)
    );

    rlf_burst_buffer u_buffer
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (accept),
        .burst      (burst),
        .load_ready (s_tready),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule
